/* rtl/core/cags_pkg.sv */
// ----------------------------------------------------------------------------
// cags_pkg: shared types and constants of the CIGAR affine-gap scorer
// Operation codes, score mode codes, register indexes, widths and the
// records that pass between the front, the queue and the back.
// ----------------------------------------------------------------------------
package cags_pkg;

   // Operation length bits taken from run_length (8..32)
   localparam int LENGTH_BITS   = 16;

   localparam int OP_KIND_W     = 3;
   localparam int RUN_LENGTH_W  = 16;
   localparam int MODE_W        = 2;
   localparam int SCORE_W       = 11;
   localparam int ACC_W         = 32;
   localparam int CSR_INDEX_W   = 4;

   // Length bits that survive both the field width and LENGTH_BITS
   localparam int EFF_LEN_BITS  = (LENGTH_BITS < RUN_LENGTH_W) ? LENGTH_BITS : RUN_LENGTH_W;
   // signed coefficient times zero-extended length
   localparam int PROD_W        = SCORE_W + EFF_LEN_BITS + 1;
   // product plus gap open
   localparam int TERM_W        = PROD_W + 1;
   localparam int SUM_W         = ACC_W + 2;

   // Queue between front and back; depth is a power of two
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   // op_kind codes
   localparam logic [OP_KIND_W-1:0] OP_MATCH    = 3'd0;
   localparam logic [OP_KIND_W-1:0] OP_MISMATCH = 3'd1;
   localparam logic [OP_KIND_W-1:0] OP_INSERT   = 3'd2;
   localparam logic [OP_KIND_W-1:0] OP_DELETE   = 3'd3;

   // score_mode codes; the unused code scores everything
   localparam logic [MODE_W-1:0] MODE_ALL       = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SKIP_DEL  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SKIP_EDGE = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MATCH      = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MISMATCH   = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GAP_OPEN   = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GAP_EXTEND = 4'd3;

   typedef logic signed [SCORE_W-1:0] score_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [TERM_W-1:0]  term_type;

   // What the back has to do with one operation
   typedef enum logic [2:0] {
      CLS_MATCH,
      CLS_MISMATCH,
      CLS_GAP,
      CLS_NULL,
      CLS_SKIP
   } op_class_type;

   typedef struct packed {
      op_class_type            cls;
      logic [EFF_LEN_BITS-1:0] len;
      logic                    first;
      logic                    last;
   } cags_item_type;

   typedef struct packed {
      logic                   full;
      logic                   empty;
      logic [QUEUE_CNT_W-1:0] count;
   } cags_q_status_type;

   typedef struct packed {
      score_type match_score;
      score_type mismatch_score;
      score_type open_score;
      score_type gap_extend_score;
   } cags_cfg_type;

   localparam score_type RESET_MATCH      = 11'sd1;
   localparam score_type RESET_MISMATCH   = -11'sd4;
   localparam score_type RESET_GAP_OPEN   = -11'sd6;
   localparam score_type RESET_GAP_EXTEND = -11'sd1;

endpackage

/* rtl/core/cags_req_if.sv */
// ----------------------------------------------------------------------------
// cags_req_if: operation channel
// One CIGAR operation per beat.
// ----------------------------------------------------------------------------
interface cags_req_if;
   logic                                valid;
   logic                                ready;
   logic [cags_pkg::OP_KIND_W-1:0]      op_kind;
   logic [cags_pkg::RUN_LENGTH_W-1:0]   run_length;
   logic                                first_element;
   logic                                closing_element;
   logic [cags_pkg::MODE_W-1:0]         score_mode;

   modport source (output valid, output op_kind, output run_length,
                   output first_element, output closing_element,
                   output score_mode, input ready);
   modport sink   (input valid, input op_kind, input run_length,
                   input first_element, input closing_element,
                   input score_mode, output ready);
endinterface

/* rtl/core/cags_rsp_if.sv */
// ----------------------------------------------------------------------------
// cags_rsp_if: result channel
// One run total per beat.
// ----------------------------------------------------------------------------
interface cags_rsp_if;
   logic                 valid;
   logic                 ready;
   cags_pkg::acc_type    total_score;
   logic                 invalid_seen;

   modport source (output valid, output total_score, output invalid_seen, input ready);
   modport sink   (input valid, input total_score, input invalid_seen, output ready);
endinterface

/* rtl/core/cags_csr_if.sv */
// ----------------------------------------------------------------------------
// cags_csr_if: register write channel
// Register index and write data per beat.
// ----------------------------------------------------------------------------
interface cags_csr_if;
   logic                               valid;
   logic                               ready;
   logic [cags_pkg::CSR_INDEX_W-1:0]   reg_index;
   cags_pkg::score_type                wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

/* rtl/core/cigar_affine_gap_scorer_unit.sv */
// ----------------------------------------------------------------------------
// cigar_affine_gap_scorer_unit: affine-gap CIGAR run scorer
// Sums match, mismatch and gap scores over a run of CIGAR operations and
// returns the saturated 32-bit total with an invalid-operation flag.
// ----------------------------------------------------------------------------
//
//   channel   dir   beat carries                                     handshake
//   req_ch    in    op_kind, run_length, first/closing flags, mode   valid/ready
//   rsp_ch    out   total_score, invalid_seen (one per run)          valid/ready
//   csr_ch    in    reg_index, wdata (score registers 0..3)          valid/ready
//
// One operation per cycle sustained while rsp_ch does not stall. A total
// reaches rsp_ch through the queue write of the beat closing its run, the
// score multiply into the s1 register and the accumulate into the output
// register. The score multiply and the saturating accumulate are the two
// register-to-register paths that set the clock.
// Reset clears the queue, accumulator, mode and loads default scores.
// A stalled rsp_ch freezes the back; the front keeps taking beats until the
// four-entry queue fills. csr_ch is always ready.
//
module cigar_affine_gap_scorer_unit (
   input  logic         clock,
   input  logic         reset,
   cags_req_if.sink     req_ch,
   cags_rsp_if.source   rsp_ch,
   cags_csr_if.sink     csr_ch
);

   cags_pkg::cags_cfg_type        cfg_ff, cfg_in;
   cags_pkg::cags_q_status_type   q_status;
   cags_pkg::cags_item_type       push_item;
   cags_pkg::cags_item_type       pop_item;
   logic                          q_push;
   logic                          q_pop;

   // --- score registers ---
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.reg_index)
            cags_pkg::REG_MATCH:      cfg_in.match_score      = csr_ch.wdata;
            cags_pkg::REG_MISMATCH:   cfg_in.mismatch_score   = csr_ch.wdata;
            cags_pkg::REG_GAP_OPEN:   cfg_in.open_score       = csr_ch.wdata;
            cags_pkg::REG_GAP_EXTEND: cfg_in.gap_extend_score = csr_ch.wdata;
            default:                  cfg_in = cfg_ff;   // unmapped index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_score      <= cags_pkg::RESET_MATCH;
         cfg_ff.mismatch_score   <= cags_pkg::RESET_MISMATCH;
         cfg_ff.open_score       <= cags_pkg::RESET_GAP_OPEN;
         cfg_ff.gap_extend_score <= cags_pkg::RESET_GAP_EXTEND;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // --- front: intake, mode tracking, classification ---
   cags_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .q_status (q_status),
      .q_push   (q_push),
      .q_item   (push_item)
   );

   // --- decoupling queue ---
   cags_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   // --- back: score, accumulate, emit ---
   cags_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_status (q_status),
      .q_pop    (q_pop),
      .q_item   (pop_item),
      .rsp      (rsp_ch)
   );

`ifndef SYNTH
   // queue occupancy never passes its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= cags_pkg::QUEUE_CNT_W'(cags_pkg::QUEUE_DEPTH))
      else $error("queue occupancy beyond depth");

   // back never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty queue");

   // a held result freezes the back
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !q_pop)
      else $error("queue popped while result stalled");

   // a beat into a queue with room shows up in its count
   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |=> (q_status.count == $past(q_status.count) + 1'b1))
      else $error("accepted beat lost from queue");
`endif

endmodule

/* rtl/core/cags_front.sv */
// ----------------------------------------------------------------------------
// cags_front: operation intake
// Accepts operations, tracks the run's mode and classifies each one.
// ----------------------------------------------------------------------------
module cags_front (
   input  logic                          clock,
   input  logic                          reset,
   cags_req_if.sink                      req,
   input  cags_pkg::cags_q_status_type   q_status,
   output logic                          q_push,
   output cags_pkg::cags_item_type       q_item
);

   logic [cags_pkg::MODE_W-1:0] active_mode_ff;
   logic [cags_pkg::MODE_W-1:0] active_mode_in;
   logic [cags_pkg::MODE_W-1:0] mode_now;
   logic                        edge_op;
   logic                        skip_del;

   assign req.ready = !q_status.full;
   assign q_push    = req.valid && req.ready;

   // a first beat loads the mode and is scored under it
   assign mode_now = req.first_element ? req.score_mode : active_mode_ff;
   assign edge_op  = req.first_element || req.closing_element;
   assign skip_del = (mode_now == cags_pkg::MODE_SKIP_DEL) ||
                     ((mode_now == cags_pkg::MODE_SKIP_EDGE) && edge_op);

   always_comb begin
      q_item.len   = req.run_length[cags_pkg::EFF_LEN_BITS-1:0];
      q_item.first = req.first_element;
      q_item.last  = req.closing_element;
      unique case (req.op_kind)
         cags_pkg::OP_MATCH:    q_item.cls = cags_pkg::CLS_MATCH;
         cags_pkg::OP_MISMATCH: q_item.cls = cags_pkg::CLS_MISMATCH;
         cags_pkg::OP_INSERT:   q_item.cls = cags_pkg::CLS_GAP;
         cags_pkg::OP_DELETE:   q_item.cls = skip_del ? cags_pkg::CLS_SKIP : cags_pkg::CLS_GAP;
         default:               q_item.cls = cags_pkg::CLS_NULL;
      endcase
   end

   assign active_mode_in = (q_push && req.first_element) ? req.score_mode : active_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_mode_ff <= cags_pkg::MODE_ALL;
      end else begin
         active_mode_ff <= active_mode_in;
      end
   end

endmodule

/* rtl/core/cags_queue.sv */
// ----------------------------------------------------------------------------
// cags_queue: classified operation queue
// Small flop FIFO between intake and scoring.
// ----------------------------------------------------------------------------
module cags_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  cags_pkg::cags_item_type       push_item,
   input  logic                          pop,
   output cags_pkg::cags_item_type       pop_item,
   output cags_pkg::cags_q_status_type   status
);

   cags_pkg::cags_item_type              mem_ff [cags_pkg::QUEUE_DEPTH];
   logic [cags_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [cags_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [cags_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;

   assign pop_item     = mem_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == cags_pkg::QUEUE_CNT_W'(cags_pkg::QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + cags_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + cags_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + cags_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - cags_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/core/cags_back.sv */
// ----------------------------------------------------------------------------
// cags_back: scoring pipeline
// Operation score (one multiply), saturating accumulate, result register.
// ----------------------------------------------------------------------------
module cags_back (
   input  logic                          clock,
   input  logic                          reset,
   input  cags_pkg::cags_cfg_type        cfg,
   input  cags_pkg::cags_q_status_type   q_status,
   output logic                          q_pop,
   input  cags_pkg::cags_item_type       q_item,
   cags_rsp_if.source                    rsp
);

   logic                                 advance;
   cags_pkg::score_type                  coef;
   logic signed [cags_pkg::PROD_W-1:0]   prod;
   cags_pkg::term_type                   term;

   // score stage
   logic                                 s1_valid_ff, s1_valid_in;
   cags_pkg::term_type                   s1_term_ff;
   logic                                 s1_err_ff;
   logic                                 s1_first_ff;
   logic                                 s1_last_ff;

   // accumulate stage
   cags_pkg::acc_type                    acc_ff, acc_in;
   logic                                 err_ff, err_in;
   cags_pkg::acc_type                    acc_base;
   logic signed [cags_pkg::SUM_W-1:0]    sum;
   cags_pkg::acc_type                    acc_sat;
   logic                                 err_sum;
   logic                                 in_range;

   // result register
   logic                                 rsp_valid_ff, rsp_valid_in;
   cags_pkg::acc_type                    rsp_total_ff;
   logic                                 rsp_err_ff;
   logic                                 emit;

   assign advance = !rsp_valid_ff || rsp.ready;
   assign q_pop   = advance && !q_status.empty;

   always_comb begin
      coef = (q_item.cls == cags_pkg::CLS_MATCH) ? cfg.match_score : cfg.gap_extend_score;
      prod = cags_pkg::PROD_W'(coef) * cags_pkg::PROD_W'($signed({1'b0, q_item.len}));
      unique case (q_item.cls) inside
         cags_pkg::CLS_MATCH:    term = cags_pkg::TERM_W'(prod);
         cags_pkg::CLS_MISMATCH: term = cags_pkg::TERM_W'(cfg.mismatch_score);
         cags_pkg::CLS_GAP:      term = cags_pkg::TERM_W'(prod) +
                                        cags_pkg::TERM_W'(cfg.open_score);
         cags_pkg::CLS_NULL, cags_pkg::CLS_SKIP: term = '0;
         default:                term = '0;
      endcase
   end

   assign s1_valid_in = advance ? q_pop : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_term_ff  <= term;
         s1_err_ff   <= (q_item.cls == cags_pkg::CLS_NULL);
         s1_first_ff <= q_item.first;
         s1_last_ff  <= q_item.last;
      end
   end

   // first beat of a run starts from zero
   always_comb begin
      acc_base = s1_first_ff ? '0 : acc_ff;
      sum      = cags_pkg::SUM_W'(acc_base) + cags_pkg::SUM_W'(s1_term_ff);
      in_range = (&sum[cags_pkg::SUM_W-1:cags_pkg::ACC_W-1]) ||
                 !(|sum[cags_pkg::SUM_W-1:cags_pkg::ACC_W-1]);
      if (in_range) begin
         acc_sat = sum[cags_pkg::ACC_W-1:0];
      end else if (sum[cags_pkg::SUM_W-1]) begin
         acc_sat = {1'b1, {(cags_pkg::ACC_W-1){1'b0}}};
      end else begin
         acc_sat = {1'b0, {(cags_pkg::ACC_W-1){1'b1}}};
      end
      err_sum = (!s1_first_ff && err_ff) || s1_err_ff;
   end

   assign emit = advance && s1_valid_ff && s1_last_ff;

   always_comb begin
      acc_in = acc_ff;
      err_in = err_ff;
      if (advance && s1_valid_ff) begin
         acc_in = s1_last_ff ? '0 : acc_sat;
         err_in = s1_last_ff ? 1'b0 : err_sum;
      end
   end

   assign rsp_valid_in = advance ? (s1_valid_ff && s1_last_ff) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_total_ff <= acc_sat;
         rsp_err_ff   <= err_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         acc_ff       <= acc_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.total_score  = rsp_total_ff;
   assign rsp.invalid_seen = rsp_err_ff;

endmodule
